// File: rtl/core/sfla_pkg.sv
// Shared widths, codes and types of the segregated free-list allocator.
package sfla_pkg;

	localparam int ACTION_W   = 1;
	localparam int SIZE_W     = 17;
	localparam int ADDR_W     = 32;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam int HDR_SHIFT = 3;
	localparam int HDR_BYTES = 8;

	localparam logic [ACTION_W-1:0] ACTION_ALLOC = 1'b0;
	localparam logic [ACTION_W-1:0] ACTION_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 1'd1;

	localparam logic [SIZE_W-1:0] POOL_SIZE_RESET = 17'h10000;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_POP  = 2'd1,
		OP_BUMP = 2'd2,
		OP_PUSH = 2'd3
	} op_t;

endpackage

// File: rtl/core/sfla_if.sv
// Handshake channels of the allocator: request, response and configuration write.
interface sfla_req_if;
	logic                               valid;
	logic                               ready;
	logic [sfla_pkg::ACTION_W-1:0]      action;
	logic [sfla_pkg::SIZE_W-1:0]        request_size;
	logic [sfla_pkg::ADDR_W-1:0]        block_address;

	modport source (output valid, action, request_size, block_address, input ready);
	modport sink (input valid, action, request_size, block_address, output ready);
endinterface

interface sfla_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [sfla_pkg::ADDR_W-1:0]        address;
	logic [sfla_pkg::STATUS_W-1:0]      status;

	modport source (output valid, address, status, input ready);
	modport sink (input valid, address, status, output ready);
endinterface

interface sfla_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [sfla_pkg::CFG_IDX_W-1:0]     index;
	logic [sfla_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/segregated_free_list_allocator_core.sv
// Top level of the segregated free-list allocator.
// Power-of-two size classes from 8 bytes up, each with a LIFO free list whose heads sit in
// flip-flops; the next-links and the per-block class tags live in two RAMs of POOL_BYTES/8
// entries with a registered read. Every item passes through ST_IDLE and then ST_EXEC: in the
// accept cycle the request is decoded and a single read of the link RAM (allocate from a list)
// or the tag RAM (free) is issued, and in ST_EXEC the read data is applied and the result is
// loaded into the output register. A new item is taken in the cycle after that, even while
// the result still waits downstream; ST_EXEC holds only when the output register is
// full and not being drained. Both RAMs need no clearing after reset, so the block is ready
// in the first cycle after reset.
module segregated_free_list_allocator_core #(
	parameter int POOL_BYTES  = 65536,
	parameter int NUM_CLASSES = 13
) (
	input logic      clk,
	input logic      arst_n,
	sfla_req_if.sink   req,
	sfla_rsp_if.source rsp,
	sfla_cfg_if.sink   cfg
);

	localparam int SLOTS  = POOL_BYTES >> sfla_pkg::HDR_SHIFT;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CLS_W  = $clog2(NUM_CLASSES);
	localparam int OFF_W  = $clog2(POOL_BYTES + 1);
	localparam int SUM_W  = ((OFF_W > sfla_pkg::SIZE_W) ? OFF_W : sfla_pkg::SIZE_W) + 2;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t                          state_q;
	logic [sfla_pkg::ADDR_W-1:0]     base_q;
	logic [sfla_pkg::SIZE_W-1:0]     size_q;
	logic [OFF_W-1:0]                bump_q;
	logic [SLOT_W-1:0]               heads_q [NUM_CLASSES];

	sfla_pkg::op_t                   op_s1;
	logic [CLS_W-1:0]                cls_s1;
	logic [SLOT_W-1:0]               slot_s1;
	logic [sfla_pkg::ADDR_W-1:0]     address_s1;
	logic [sfla_pkg::STATUS_W-1:0]   status_s1;

	logic                            out_valid_q;
	logic [sfla_pkg::ADDR_W-1:0]     out_address_q;
	logic [sfla_pkg::STATUS_W-1:0]   out_status_q;

	logic                            accept;
	logic                            exec_go;
	logic [CLS_W-1:0]                cls;
	logic                            cls_ok;
	logic [CLS_W-1:0]                head_idx;
	logic [SLOT_W-1:0]               head_rd;
	logic [SUM_W-1:0]                cap;
	logic [SUM_W-1:0]                need;
	logic                            exceed;
	logic [OFF_W-1:0]                payload;
	logic [sfla_pkg::ADDR_W-1:0]     off;
	logic                            free_ok;
	logic [SLOT_W-1:0]               free_slot;
	sfla_pkg::op_t                   op_d;
	logic [sfla_pkg::STATUS_W-1:0]   status_d;
	logic [sfla_pkg::ADDR_W-1:0]     address_d;
	logic [SLOT_W-1:0]               slot_d;
	logic [SLOT_W-1:0]               link_rdata;
	logic [CLS_W-1:0]                tag_rdata;
	logic                            tag_ok;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid   = out_valid_q;
	assign rsp.address = out_address_q;
	assign rsp.status  = out_status_q;

	assign accept  = req.valid && (state_q == ST_IDLE);
	assign exec_go = (state_q == ST_EXEC) && (!out_valid_q || rsp.ready);

	// Smallest class whose block size covers the request.
	always_comb begin
		cls    = '0;
		cls_ok = 1'b0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if ((64'(sfla_pkg::HDR_BYTES) << c) >= 64'(req.request_size)) begin
				cls    = CLS_W'(c);
				cls_ok = 1'b1;
			end
		end
		if (req.request_size == '0) begin
			cls_ok = 1'b0;
		end
	end

	always_comb begin
		if (state_q == ST_IDLE) begin
			head_idx = cls;
		end else if (op_s1 == sfla_pkg::OP_POP) begin
			head_idx = cls_s1;
		end else begin
			head_idx = tag_rdata;
		end
	end

	assign head_rd = heads_q[head_idx];

	assign cap     = (SUM_W'(size_q) < SUM_W'(POOL_BYTES)) ? SUM_W'(size_q) : SUM_W'(POOL_BYTES);
	assign need    = SUM_W'(sfla_pkg::HDR_BYTES) + (SUM_W'(sfla_pkg::HDR_BYTES) << cls);
	assign exceed  = (SUM_W'(bump_q) + need) > cap;
	assign payload = bump_q + OFF_W'(sfla_pkg::HDR_BYTES);

	assign off       = req.block_address - base_q;
	assign free_ok   = (off[sfla_pkg::HDR_SHIFT-1:0] == '0) && (off != '0) &&
		(off < sfla_pkg::ADDR_W'(POOL_BYTES));
	assign free_slot = off[SLOT_W+sfla_pkg::HDR_SHIFT-1:sfla_pkg::HDR_SHIFT];

	assign tag_ok = (CLS_W + 1)'(tag_rdata) < (CLS_W + 1)'(NUM_CLASSES);

	always_comb begin
		op_d      = sfla_pkg::OP_NONE;
		status_d  = sfla_pkg::STATUS_OK;
		address_d = '0;
		slot_d    = free_slot;
		if (req.action == sfla_pkg::ACTION_ALLOC) begin
			slot_d = head_rd;
			if (!cls_ok) begin
				status_d = sfla_pkg::STATUS_BAD_SIZE;
			end else if (head_rd != '0) begin
				op_d      = sfla_pkg::OP_POP;
				address_d = base_q + (sfla_pkg::ADDR_W'(head_rd) << sfla_pkg::HDR_SHIFT);
			end else if (exceed) begin
				status_d = sfla_pkg::STATUS_EXHAUSTED;
			end else begin
				op_d      = sfla_pkg::OP_BUMP;
				address_d = base_q + sfla_pkg::ADDR_W'(payload);
			end
		end else if (free_ok) begin
			op_d = sfla_pkg::OP_PUSH;
		end
	end

	sfla_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOTS)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (exec_go && (op_s1 == sfla_pkg::OP_PUSH) && tag_ok),
		.wr_addr (slot_s1),
		.wr_data (head_rd),
		.rd_en   (accept && (op_d == sfla_pkg::OP_POP)),
		.rd_addr (head_rd),
		.rd_data (link_rdata)
	);

	sfla_ram #(
		.WIDTH (CLS_W),
		.DEPTH (SLOTS)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (accept && (op_d == sfla_pkg::OP_BUMP)),
		.wr_addr (payload[SLOT_W+sfla_pkg::HDR_SHIFT-1:sfla_pkg::HDR_SHIFT]),
		.wr_data (cls),
		.rd_en   (accept && (op_d == sfla_pkg::OP_PUSH)),
		.rd_addr (free_slot),
		.rd_data (tag_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			size_q      <= sfla_pkg::POOL_SIZE_RESET;
			bump_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				heads_q[i] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					sfla_pkg::REG_POOL_BASE: base_q <= cfg.data;
					sfla_pkg::REG_POOL_SIZE: size_q <= cfg.data[sfla_pkg::SIZE_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
						if (op_d == sfla_pkg::OP_BUMP) begin
							bump_q <= OFF_W'(SUM_W'(bump_q) + need);
						end
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
						if (op_s1 == sfla_pkg::OP_POP) begin
							heads_q[head_idx] <= link_rdata;
						end else if ((op_s1 == sfla_pkg::OP_PUSH) && tag_ok) begin
							heads_q[head_idx] <= slot_s1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op_d;
			cls_s1     <= cls;
			slot_s1    <= slot_d;
			address_s1 <= address_d;
			status_s1  <= status_d;
		end
		if (exec_go) begin
			out_address_q <= address_s1;
			out_status_q  <= status_s1;
		end
	end

`ifndef SYNTHESIS
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted item did not move to the execute cycle");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result appeared without an execute cycle");

	a_bump_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q <= OFF_W'(POOL_BYTES))
		else $error("bump offset ran past the pool");

	a_fail_zero_address: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != sfla_pkg::STATUS_OK)) |-> (out_address_q == '0))
		else $error("failed allocate returned a nonzero address");
`endif

endmodule

// File: rtl/core/sfla_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module sfla_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 8192,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
